[hdl/cht_pkg.sv]
// cht_pkg: shared field widths, command and status codes for the chained hash table
// used by cht_mod_unit and chained_hash_table; depends on nothing

package cht_pkg;

   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 64;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   // key remainder is worked out eight key bits per cycle, msb first
   localparam int HASH_CHUNK = 8;
   localparam int HASH_STEPS = 4;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_LOOKUP = 2'd2;

   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_REPLACED  = 3'd1;
   localparam status_type ST_REMOVED   = 3'd2;
   localparam status_type ST_NOT_FOUND = 3'd3;
   localparam status_type ST_FULL      = 3'd4;
   localparam status_type ST_FOUND     = 3'd5;

endpackage

[hdl/cht_ram.sv]
// cht_ram: generic single-write, single-read ram with registered read data
// no dependencies

module cht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cht_mod_unit.sv]
// cht_mod_unit: iterative key modulo bucket count, one compare-subtract chain per cycle
// depends on cht_pkg

module cht_mod_unit #(
   parameter int BUCKETS = 10,
   localparam int RW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cht_pkg::key_type key,
   output logic             done,
   output logic [RW-1:0]    rem
);

   import cht_pkg::*;

   localparam int PAD_W = HASH_CHUNK * HASH_STEPS;
   localparam int SW    = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [SW-1:0]    step_ff;
   logic [RW-1:0]    rem_ff;
   logic [RW-1:0]    rem_in;
   logic [PAD_W-1:0] shift_ff;

   always_comb begin : chunk
      logic [RW:0]   trial;
      logic [RW-1:0] part;
      part = rem_ff;
      for (int i = 0; i < HASH_CHUNK; i++) begin
         trial = {part, shift_ff[PAD_W-1-i]};
         if (trial >= (RW+1)'(BUCKETS)) begin
            trial = trial - (RW+1)'(BUCKETS);
         end
         part = trial[RW-1:0];
      end
      rem_in = part;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + SW'(1);
            if (step_ff == SW'(HASH_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= '0;
         shift_ff <= {{(PAD_W - KEY_W){1'b0}}, key};
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_ff << HASH_CHUNK;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

[hdl/chained_hash_table.sv]
// chained_hash_table: key-value table, BUCKETS buckets of WAYS slots, one request at a time
// depends on cht_pkg, cht_mod_unit and cht_ram
// the bucket scan stops early on a key match, which shortens the time to the response
// req_stall stays high until the response is issued; the iterative key modulo unit and the
// one-slot-per-cycle scan of the bucket through the ram read port set the time per request
// reset: synchronous; then a pass clears all BUCKETS * WAYS slots, stall high meanwhile

module chained_hash_table #(
   parameter int BUCKETS = 10,
   parameter int WAYS    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [cht_pkg::CMD_W-1:0]  req_command,
   input  cht_pkg::key_type           req_key,
   input  cht_pkg::value_type         req_value_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cht_pkg::status_type        rsp_status,
   output cht_pkg::value_type         rsp_value_out,
   output logic                       rsp_table_empty
);

   import cht_pkg::*;

   localparam int SLOTS = BUCKETS * WAYS;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int KR_W  = KEY_W + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_SCAN,
      S_ACT,
      S_RESP
   } state_type;

   state_type        state_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic [CW-1:0]    count_ff;
   cmd_type          cmd_ff;
   key_type          key_ff;
   value_type        val_ff;
   logic [AW-1:0]    base_ff;
   logic [WW-1:0]    rd_way_ff;
   logic             issue_ff;
   logic             chk_ff;
   logic             chk_last_ff;
   logic [AW-1:0]    chk_addr_ff;
   logic             hit_ff;
   logic [AW-1:0]    hit_addr_ff;
   logic             free_ff;
   logic [AW-1:0]    free_addr_ff;
   value_type        val_cap_ff;
   status_type       status_ff;
   value_type        value_ff;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   value_type        rsp_value_ff;
   logic             rsp_empty_ff;

   logic             mod_start;
   logic             mod_done;
   logic [RW-1:0]    mod_rem;

   logic [AW-1:0]    rd_addr;
   logic [KR_W-1:0]  key_rd;
   value_type        val_rd;
   logic             key_wr_en;
   logic [AW-1:0]    key_wr_addr;
   logic [KR_W-1:0]  key_wr_data;
   logic             val_wr_en;
   logic [AW-1:0]    val_wr_addr;
   value_type        val_wr_data;

   status_type       act_status;
   value_type        act_value;
   logic             cnt_inc;
   logic             cnt_dec;
   logic             key_match;

   assign req_stall = (state_ff != S_IDLE);
   assign mod_start = (state_ff == S_IDLE) && req_valid;
   assign rd_addr   = base_ff + AW'(rd_way_ff);
   assign key_match = key_rd[KEY_W] && (key_rd[KEY_W-1:0] == key_ff);

   cht_mod_unit #(
      .BUCKETS(BUCKETS)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .key   (req_key),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   // bit KEY_W of each entry is the slot valid mark
   cht_ram #(
      .WIDTH(KR_W),
      .DEPTH(SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   cht_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(SLOTS)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   always_comb begin
      key_wr_en   = 1'b0;
      key_wr_addr = clr_addr_ff;
      key_wr_data = '0;
      val_wr_en   = 1'b0;
      val_wr_addr = hit_addr_ff;
      val_wr_data = val_ff;
      act_status  = ST_NOT_FOUND;
      act_value   = '0;
      cnt_inc     = 1'b0;
      cnt_dec     = 1'b0;
      if (state_ff == S_CLEAR) begin
         key_wr_en = 1'b1;
      end
      if (state_ff == S_ACT) begin
         unique case (cmd_ff)
            CMD_INSERT: begin
               if (hit_ff) begin
                  val_wr_en  = 1'b1;
                  act_status = ST_REPLACED;
               end else if (free_ff) begin
                  key_wr_en   = 1'b1;
                  key_wr_addr = free_addr_ff;
                  key_wr_data = {1'b1, key_ff};
                  val_wr_en   = 1'b1;
                  val_wr_addr = free_addr_ff;
                  act_status  = ST_INSERTED;
                  cnt_inc     = 1'b1;
               end else begin
                  act_status = ST_FULL;
               end
            end
            CMD_REMOVE: begin
               if (hit_ff) begin
                  key_wr_en   = 1'b1;
                  key_wr_addr = hit_addr_ff;
                  key_wr_data = {1'b0, key_ff};
                  act_status  = ST_REMOVED;
                  cnt_dec     = 1'b1;
               end
            end
            CMD_LOOKUP: begin
               if (hit_ff) begin
                  act_status = ST_FOUND;
                  act_value  = val_cap_ff;
               end
            end
            default: begin
               act_status = ST_NOT_FOUND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rd_way_ff    <= '0;
         issue_ff     <= 1'b0;
         chk_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == AW'(SLOTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  key_ff   <= req_key;
                  val_ff   <= req_value_in;
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               if (mod_done) begin
                  base_ff   <= AW'(mod_rem) * AW'(WAYS);
                  rd_way_ff <= '0;
                  issue_ff  <= 1'b1;
                  chk_ff    <= 1'b0;
                  hit_ff    <= 1'b0;
                  free_ff   <= 1'b0;
                  state_ff  <= S_SCAN;
               end
            end
            S_SCAN: begin
               chk_ff <= issue_ff;
               if (issue_ff) begin
                  chk_addr_ff <= rd_addr;
                  chk_last_ff <= (rd_way_ff == WW'(WAYS - 1));
                  if (rd_way_ff == WW'(WAYS - 1)) begin
                     issue_ff <= 1'b0;
                  end else begin
                     rd_way_ff <= rd_way_ff + WW'(1);
                  end
               end
               if (chk_ff) begin
                  if (key_match) begin
                     hit_ff      <= 1'b1;
                     hit_addr_ff <= chk_addr_ff;
                     val_cap_ff  <= val_rd;
                     issue_ff    <= 1'b0;
                     state_ff    <= S_ACT;
                  end else begin
                     if (!key_rd[KEY_W] && !free_ff) begin
                        free_ff      <= 1'b1;
                        free_addr_ff <= chk_addr_ff;
                     end
                     if (chk_last_ff) begin
                        state_ff <= S_ACT;
                     end
                  end
               end
            end
            S_ACT: begin
               status_ff <= act_status;
               value_ff  <= act_value;
               if (cnt_inc) begin
                  count_ff <= count_ff + CW'(1);
               end else if (cnt_dec && (count_ff != '0)) begin
                  count_ff <= count_ff - CW'(1);
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_value_ff  <= value_ff;
                  rsp_empty_ff  <= (count_ff == '0);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_table_empty = rsp_empty_ff;

   a_value_only_on_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_FOUND) |-> (rsp_value_ff == '0))
      else $error("value returned with a status other than found");

   a_insert_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_INSERTED) |-> !rsp_empty_ff)
      else $error("table reported empty right after an insert");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("entry count exceeds slot count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1))
               || (count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

endmodule
